FILE: rtl/assert_macros.svh
// Assertion macros for the RTL of the keypad scanner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define KPS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a trigger implies a consequence in the same cycle.
`define KPS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a trigger implies a consequence in the next cycle.
`define KPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/kpsve_pkg.sv
// Package with types and constants of the keypad scanner with value entry.
`timescale 1ns / 1ps
`default_nettype none

package kpsve_pkg;

	localparam int unsigned TICK_W  = 24;
	localparam int unsigned VALUE_W = 10;
	localparam int unsigned ROW_W   = 2;
	localparam int unsigned KEYS    = 9;
	localparam int unsigned COLS    = 3;

	// Register indexes of the configuration port
	localparam logic CFG_SCAN_PERIOD = 1'b0;
	localparam logic CFG_MAX_CODE    = 1'b1;

	// Reset values of the configuration registers
	localparam logic [TICK_W-1:0]  SCAN_PERIOD_RST = 24'd100000;
	localparam logic [VALUE_W-1:0] MAX_CODE_RST    = 10'd720;

	localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

	// Row indexes
	localparam logic [ROW_W-1:0] ROW_0 = 2'd0;
	localparam logic [ROW_W-1:0] ROW_1 = 2'd1;
	localparam logic [ROW_W-1:0] ROW_2 = 2'd2;

	// Step sizes of the entry keys (one bit wider than a value)
	localparam logic [VALUE_W:0] STEP_HUNDRED = 11'd100;
	localparam logic [VALUE_W:0] STEP_TEN     = 11'd10;
	localparam logic [VALUE_W:0] STEP_ONE     = 11'd1;

	// Key index, row times three plus column, and the action it selects
	typedef enum logic [3:0] {
		KEY_ADD_HUNDRED = 4'd0,
		KEY_ADD_TEN     = 4'd1,
		KEY_ADD_ONE     = 4'd2,
		KEY_SUB_HUNDRED = 4'd3,
		KEY_SUB_TEN     = 4'd4,
		KEY_SUB_ONE     = 4'd5,
		KEY_OK          = 4'd6,
		KEY_ZERO        = 4'd7,
		KEY_CANCEL      = 4'd8
	} key_t;

endpackage

`default_nettype wire

FILE: rtl/keypad_scan_value_entry_core.sv
// Top level: 3x3 keypad row scanner that turns key presses into an entered value.
//
//  channel | dir | handshake               | word
//  --------+-----+-------------------------+------------------------------------------
//  s_*     | in  | s_tvalid / s_tready     | one tick: column levels, active low
//  m_*     | out | m_tvalid / m_tready     | one result per tick: row, key, values
//  cfg_*   | in  | cfg_we, no wait         | scan period (index 0), max code (index 1)
//
// One word enters per cycle while m_tready does not stall the output register.
// A tick is registered, then evaluated against the scan and entry state in one
// pass (24-bit tick increment and compare, then a 10-bit add/clamp) into the
// output register. Stalling m_tready holds the output register and the input
// register; input is still taken while the output register drains.
// Reset (arst_n low) clears the valid flags and the scan and entry state and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module keypad_scan_value_entry_core
	import kpsve_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input ticks
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [7:0]  s_tdata,   // [2:0] column_levels, [7:3] zero
	// results
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [39:0] m_tdata,   // [1:0] row_select, [5:2] key_index,
	                                    // [15:6] entry_value, [25:16] confirmed_value,
	                                    // [35:26] previous_value, [39:36] zero
	output      logic [1:0]  m_tuser,   // [0] scan_done, [1] key_valid
	// configuration writes
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [23:0] cfg_data
);

	// configuration registers
	logic [TICK_W-1:0]  scan_period_q;
	logic [VALUE_W-1:0] max_code_q;

	// scan and entry state
	logic [TICK_W-1:0]  elapsed_q;
	logic [ROW_W-1:0]   scan_row_q;
	logic [KEYS-1:0]    key_map_q;
	logic [VALUE_W-1:0] entry_q;
	logic [VALUE_W-1:0] confirmed_q;
	logic [VALUE_W-1:0] previous_q;

	// pipeline registers
	logic               valid_s1;
	logic [COLS-1:0]    cols_s1;
	logic               valid_s2;
	logic [39:0]        data_s2;
	logic [1:0]         user_s2;

	// combinational results of the evaluation pass
	logic               adv;
	logic [TICK_W-1:0]  elapsed_inc;
	logic               scan;
	logic               hit;
	logic [COLS-1:0]    pressed;
	logic [KEYS-1:0]    key_map_nx;
	logic [ROW_W-1:0]   scan_row_nx;
	key_t               key_idx;
	logic [VALUE_W:0]   entry_wide;
	logic [VALUE_W:0]   entry_act;
	logic [VALUE_W-1:0] entry_nx;
	logic [VALUE_W-1:0] confirmed_nx;
	logic [VALUE_W-1:0] previous_nx;
	logic [TICK_W-1:0]  elapsed_nx;

	// Advance when the stage-1 word can move into a free or draining output register
	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;
	assign m_tuser  = user_s2;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_period_q <= SCAN_PERIOD_RST;
			max_code_q    <= MAX_CODE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SCAN_PERIOD: scan_period_q <= cfg_data;
				CFG_MAX_CODE:    max_code_q    <= cfg_data[VALUE_W-1:0];
				default:         ;
			endcase
		end
	end

	// Input register: take a tick whenever stage 1 is empty or moving on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cols_s1 <= s_tdata[COLS-1:0];
		end
	end

	// Count ticks, saturating, and decide whether this tick scans a row
	always_comb begin
		elapsed_inc = (elapsed_q == TICK_MAX) ? elapsed_q : elapsed_q + 1'b1;
		scan        = (elapsed_inc >= scan_period_q);
		elapsed_nx  = scan ? '0 : elapsed_inc;
		pressed     = ~cols_s1;
		hit         = scan && (pressed != '0);
	end

	// Record the scanned row in the key map and step to the next row
	always_comb begin
		key_map_nx  = key_map_q;
		scan_row_nx = scan_row_q;
		if (scan) begin
			case (scan_row_q)
				ROW_0: begin
					key_map_nx[2:0] = pressed;
					scan_row_nx     = ROW_1;
				end
				ROW_1: begin
					key_map_nx[5:3] = pressed;
					scan_row_nx     = ROW_2;
				end
				default: begin
					key_map_nx[8:6] = pressed;
					scan_row_nx     = ROW_0;
				end
			endcase
		end
	end

	// Pick the lowest pressed key of the whole map
	always_comb begin
		key_idx = KEY_ADD_HUNDRED;
		for (int i = KEYS - 1; i >= 0; i--) begin
			if (key_map_nx[i]) begin
				key_idx = key_t'(4'(i));
			end
		end
		if (!hit) begin
			key_idx = KEY_ADD_HUNDRED;
		end
	end

	// Apply the key action, then clamp the entry to the max code
	always_comb begin
		entry_wide   = {1'b0, entry_q};
		entry_act    = entry_wide;
		confirmed_nx = confirmed_q;
		previous_nx  = previous_q;
		case (key_idx)
			KEY_ADD_HUNDRED: entry_act = entry_wide + STEP_HUNDRED;
			KEY_ADD_TEN:     entry_act = entry_wide + STEP_TEN;
			KEY_ADD_ONE:     entry_act = entry_wide + STEP_ONE;
			KEY_SUB_HUNDRED: entry_act = (entry_wide < STEP_HUNDRED) ? '0 :
			                             entry_wide - STEP_HUNDRED;
			KEY_SUB_TEN:     entry_act = (entry_wide < STEP_TEN) ? '0 :
			                             entry_wide - STEP_TEN;
			KEY_SUB_ONE:     entry_act = (entry_wide < STEP_ONE) ? '0 :
			                             entry_wide - STEP_ONE;
			KEY_OK: begin
				previous_nx  = confirmed_q;
				confirmed_nx = entry_q;
			end
			KEY_ZERO:        confirmed_nx = '0;
			KEY_CANCEL:      entry_act = '0;
			default:         entry_act = '0;
		endcase
		entry_nx = (entry_act > {1'b0, max_code_q}) ? max_code_q : entry_act[VALUE_W-1:0];
		if (!hit) begin
			entry_nx     = entry_q;
			confirmed_nx = confirmed_q;
			previous_nx  = previous_q;
		end
	end

	// State registers: update once per evaluated tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q   <= '0;
			scan_row_q  <= ROW_0;
			key_map_q   <= '0;
			entry_q     <= '0;
			confirmed_q <= '0;
			previous_q  <= '0;
		end else if (adv) begin
			elapsed_q   <= elapsed_nx;
			scan_row_q  <= scan_row_nx;
			key_map_q   <= key_map_nx;
			entry_q     <= entry_nx;
			confirmed_q <= confirmed_nx;
			previous_q  <= previous_nx;
		end
	end

	// Output register: load on advance, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s2 <= {4'b0000, previous_nx, confirmed_nx, entry_nx,
			            4'(key_idx), scan_row_nx};
			user_s2 <= {hit, scan};
		end
	end

	// Checks on the scan and entry logic
	`KPS_ASSERT(a_row_range, scan_row_q != 2'd3, "scan row left the range 0..2")
	`KPS_ASSERT_IMPL(a_key_needs_scan, m_tvalid && m_tuser[1], m_tuser[0],
		"key action reported without a row scan")
	`KPS_ASSERT_NEXT(a_scan_clears_count, adv && scan, elapsed_q == '0,
		"tick count not cleared after a scan")
	`KPS_ASSERT_NEXT(a_entry_clamped, adv && hit && !cfg_we,
		(entry_q <= max_code_q) || $past(cfg_we), "entry above max code after a key action")

endmodule

`default_nettype wire

FILE: sim/tb_keypad_scan_value_entry_core.sv
// Testbench for the keypad scanner: directed and random ticks checked against a scan and entry predictor.
`timescale 1ns / 1ps

module tb_keypad_scan_value_entry_core;
	import kpsve_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 1000;
	localparam int unsigned DRAIN_CYCLES   = 4;

	// one expected result word
	typedef struct {
		logic [ROW_W-1:0]   row_select;
		logic               scan_done;
		logic               key_valid;
		key_t               key_index;
		logic [VALUE_W-1:0] entry_value;
		logic [VALUE_W-1:0] confirmed_value;
		logic [VALUE_W-1:0] previous_value;
	} entry_result_t;

	// Predicts the scan and entry state and checks result words in order
	class entry_scoreboard;
		logic [TICK_W-1:0]  period;
		logic [VALUE_W-1:0] max_value;
		logic [TICK_W-1:0]  elapsed;
		logic [ROW_W-1:0]   row;
		logic [KEYS-1:0]    key_map;
		logic [VALUE_W-1:0] entry;
		logic [VALUE_W-1:0] confirmed;
		logic [VALUE_W-1:0] previous;
		entry_result_t      pending_results[$];
		int unsigned        mismatches;

		function new();
			period     = SCAN_PERIOD_RST;
			max_value  = MAX_CODE_RST;
			elapsed    = '0;
			row        = ROW_0;
			key_map    = '0;
			entry      = '0;
			confirmed  = '0;
			previous   = '0;
			mismatches = 0;
		endfunction

		function void set_register(logic index, logic [TICK_W-1:0] value);
			if (index == CFG_SCAN_PERIOD) begin
				period = value;
			end else begin
				max_value = value[VALUE_W-1:0];
			end
		endfunction

		// Advance the state by one tick and queue its result
		function void note_tick(logic [COLS-1:0] cols);
			entry_result_t   r;
			logic            hit;
			logic [VALUE_W:0] sum;
			logic [VALUE_W:0] step;
			int              base;
			hit = 1'b0;
			r.scan_done = 1'b0;
			r.key_valid = 1'b0;
			r.key_index = KEY_ADD_HUNDRED;
			if (elapsed != TICK_MAX) begin
				elapsed = elapsed + 1'b1;
			end
			// scan the current row and move to the next
			if (elapsed >= period) begin
				elapsed = '0;
				r.scan_done = 1'b1;
				base = int'(row) * 3;
				for (int i = 0; i < COLS; i++) begin
					key_map[base + i] = ~cols[i];
					if (!cols[i]) begin
						hit = 1'b1;
					end
				end
				row = (row == ROW_2) ? ROW_0 : row + 1'b1;
			end
			// lowest key in the map picks the action
			if (hit) begin
				for (int i = KEYS - 1; i >= 0; i--) begin
					if (key_map[i]) begin
						r.key_index = key_t'(4'(i));
					end
				end
				r.key_valid = 1'b1;
				sum = {1'b0, entry};
				case (r.key_index)
					KEY_ADD_HUNDRED, KEY_ADD_TEN, KEY_ADD_ONE: begin
						step = (r.key_index == KEY_ADD_HUNDRED) ? STEP_HUNDRED :
						       (r.key_index == KEY_ADD_TEN) ? STEP_TEN : STEP_ONE;
						sum = {1'b0, entry} + step;
					end
					KEY_SUB_HUNDRED, KEY_SUB_TEN, KEY_SUB_ONE: begin
						step = (r.key_index == KEY_SUB_HUNDRED) ? STEP_HUNDRED :
						       (r.key_index == KEY_SUB_TEN) ? STEP_TEN : STEP_ONE;
						sum = ({1'b0, entry} < step) ? '0 : {1'b0, entry} - step;
					end
					KEY_OK: begin
						previous  = confirmed;
						confirmed = entry;
					end
					KEY_ZERO: begin
						confirmed = '0;
					end
					default: begin
						sum = '0;
					end
				endcase
				// clamp to the upper limit
				if (sum > {1'b0, max_value}) begin
					sum = {1'b0, max_value};
				end
				entry = sum[VALUE_W-1:0];
			end
			r.row_select      = row;
			r.entry_value     = entry;
			r.confirmed_value = confirmed;
			r.previous_value  = previous;
			pending_results.push_back(r);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				mismatches++;
			end
		endfunction

		// Check one result word against the oldest expectation
		function void check_result(logic [39:0] data, logic [1:0] user);
			entry_result_t r;
			if (pending_results.size() == 0) begin
				$display("%0t: result word with nothing expected, actual data %h user %b",
					$time, data, user);
				mismatches++;
				return;
			end
			r = pending_results.pop_front();
			compare_field("row_select", r.row_select, data[1:0]);
			compare_field("key_index", r.key_index, data[5:2]);
			compare_field("entry_value", r.entry_value, data[15:6]);
			compare_field("confirmed_value", r.confirmed_value, data[25:16]);
			compare_field("previous_value", r.previous_value, data[35:26]);
			compare_field("scan_done", r.scan_done, user[0]);
			compare_field("key_valid", r.key_valid, user[1]);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [2:0] column_levels, [7:3] zero
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // [1:0] row, [5:2] key, [15:6] entry, [25:16] confirmed,
	                        // [35:26] previous, [39:36] zero
	logic [1:0]  m_tuser;   // [0] scan_done, [1] key_valid
	logic        cfg_we;
	logic        cfg_index;
	logic [23:0] cfg_data;

	entry_scoreboard sb = new();
	int unsigned     idle_pct;
	int unsigned     stall_pct;
	int unsigned     quiet_cycles;

	keypad_scan_value_entry_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Stall the result side at random
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Note accepted ticks and check accepted result words
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				sb.note_tick(s_tdata[COLS-1:0]);
			end
			if (m_tvalid && m_tready) begin
				sb.check_result(m_tdata, m_tuser);
			end
		end
	end

	// End the run when no word moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Offer one tick, idling at random first, and hold it until taken
	task automatic send_tick(input logic [COLS-1:0] cols);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, cols};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
	endtask

	// Stop sending and wait until every expected word has come back
	task automatic drain;
		s_tvalid <= 1'b0;
		// let the last accepted tick reach the scoreboard first
		@(posedge clk);
		while (sb.pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write both registers while the block is idle
	task automatic program_block(input logic [TICK_W-1:0] period,
			input logic [VALUE_W-1:0] max_value);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_SCAN_PERIOD;
		cfg_data  <= period;
		sb.set_register(CFG_SCAN_PERIOD, period);
		@(posedge clk);
		cfg_index <= CFG_MAX_CODE;
		cfg_data  <= {14'b0, max_value};
		sb.set_register(CFG_MAX_CODE, {14'b0, max_value});
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		// ten row sweeps at period 1: each key in turn, stale keys, clamping at both ends
		logic [COLS-1:0] directed_cols [30] = '{
			3'b110, 3'b000, 3'b111,  3'b101, 3'b111, 3'b111,  3'b011, 3'b111, 3'b111,
			3'b111, 3'b111, 3'b110,  3'b111, 3'b110, 3'b000,  3'b111, 3'b101, 3'b111,
			3'b111, 3'b011, 3'b111,  3'b111, 3'b111, 3'b101,  3'b110, 3'b111, 3'b011,
			3'b111, 3'b111, 3'b011
		};
		// random phases: zero period, period far above the count then lowered below it,
		// limit at both extremes and lowered below the entry
		int unsigned phase_items [7] = '{250, 250, 200, 250, 40, 150, 200};
		int unsigned phase_period[7] = '{1, 3, 0, 2, 24'hFFFFFF, 4, 1};
		int unsigned phase_max   [7] = '{1023, 400, 0, 1023, 1023, 12, 1023};
		int unsigned phase_idle  [7] = '{0, 63, 0, 24, 24, 63, 0};
		int unsigned phase_stall [7] = '{0, 0, 63, 24, 24, 63, 0};
		logic [COLS-1:0] cols;

		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		m_tready     = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = CFG_SCAN_PERIOD;
		cfg_data     = '0;
		idle_pct     = 0;
		stall_pct    = 0;
		quiet_cycles = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// a few ticks at the reset period: no scan yet
		for (int i = 0; i < 3; i++) begin
			send_tick(3'b000);
		end
		drain();
		program_block(24'd1, 10'd150);
		foreach (directed_cols[i]) begin
			send_tick(directed_cols[i]);
		end

		for (int p = 0; p < 7; p++) begin
			drain();
			program_block(TICK_W'(phase_period[p]), VALUE_W'(phase_max[p]));
			idle_pct  = phase_idle[p];
			stall_pct = phase_stall[p];
			for (int i = 0; i < phase_items[p]; i++) begin
				// keys up often so that presses and releases alternate
				if ($urandom_range(0, 99) < 40) begin
					cols = 3'b111;
				end else begin
					cols = COLS'($urandom_range(0, 7));
				end
				send_tick(cols);
			end
		end

		idle_pct  = 0;
		stall_pct = 0;
		drain();
		if (sb.mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/kpsve_pkg.sv
rtl/keypad_scan_value_entry_core.sv
sim/tb_keypad_scan_value_entry_core.sv
